### rtl/lot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker package
// Shared command and error codes, port widths, parameter defaults and the
// result record handed from the order stack to the top level.
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DEFAULT_KEY_BITS = 32;

    // Widths of the ports, fixed regardless of the parameters.
    localparam int KEY_PORT_BITS    = 32;
    localparam int POPPED_BITS      = 32;
    localparam int COUNT_OUT_BITS   = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TOUCH  = 2'd2,
        CMD_POP    = 2'd3
    } lot_cmd_t;

    typedef enum logic [2:0] {
        ERR_OK      = 3'd0,
        ERR_ZERO    = 3'd1,
        ERR_PRESENT = 3'd2,
        ERR_ABSENT  = 3'd3,
        ERR_EMPTY   = 3'd4,
        ERR_FULL    = 3'd5
    } lot_err_t;

    typedef struct packed {
        logic [POPPED_BITS-1:0]    popped_key;
        lot_err_t                  error;
        logic [COUNT_OUT_BITS-1:0] count_after;
        logic                      is_empty;
    } lot_result_t;

endpackage
`default_nettype wire

### rtl/lot_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order stack
// Holds the keys from least recent (slot 0) to most recent, matches a key
// against all held slots in parallel and applies one command per fire.
// ----------------------------------------------------------------------------
module lot_stack
    import lot_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int KEY_BITS = DEFAULT_KEY_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire lot_cmd_t            cmd,
    input  wire logic [KEY_BITS-1:0] key,
    output lot_result_t              result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_BITS-1:0] slot_reg [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       count_last;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] after;
    logic [CAPACITY-1:0] shift_en;
    logic [CAPACITY-1:0] load_en;

    logic     hit;
    logic     key_zero;
    logic     is_full;
    lot_err_t err;
    logic     ok;
    logic     add_ok;
    logic     remove_ok;
    logic     touch_ok;
    logic     pop_ok;

    assign count_last = count_reg - CW'(1);
    assign hit        = |match;
    assign key_zero   = (key == '0);
    assign is_full    = (count_reg >= CW'(CAPACITY));

    for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
        localparam int SRC = (i == CAPACITY - 1) ? i : i + 1;

        assign match[i] = (CW'(i) < count_reg) && (slot_reg[i] == key);
        // A slot at or above the matching one closes the gap left by it.
        assign after[i] = |match[i:0];

        assign load_en[i]  = (add_ok && (CW'(i) == count_reg))
                           || (touch_ok && (CW'(i) == count_last));
        assign shift_en[i] = pop_ok || ((remove_ok || touch_ok) && after[i]);

        always_ff @(posedge clk)
        begin
            if (fire && load_en[i])
            begin
                slot_reg[i] <= key;
            end
            else if (fire && shift_en[i])
            begin
                slot_reg[i] <= slot_reg[SRC];
            end
        end
    end

    always_comb
    begin
        err = ERR_OK;
        unique case (cmd)
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    err = ERR_EMPTY;
                end
            end
            CMD_ADD:
            begin
                priority if (key_zero)
                begin
                    err = ERR_ZERO;
                end
                else if (hit)
                begin
                    err = ERR_PRESENT;
                end
                else if (is_full)
                begin
                    err = ERR_FULL;
                end
            end
            CMD_REMOVE, CMD_TOUCH:
            begin
                priority if (key_zero)
                begin
                    err = ERR_ZERO;
                end
                else if (!hit)
                begin
                    err = ERR_ABSENT;
                end
            end
            default:
            begin
                err = ERR_OK;
            end
        endcase
    end

    assign ok        = (err == ERR_OK);
    assign add_ok    = ok && (cmd == CMD_ADD);
    assign remove_ok = ok && (cmd == CMD_REMOVE);
    assign touch_ok  = ok && (cmd == CMD_TOUCH);
    assign pop_ok    = ok && (cmd == CMD_POP);

    always_comb
    begin
        priority if (add_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok || remove_ok)
        begin
            count_next = count_last;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        result.popped_key  = pop_ok ? POPPED_BITS'(slot_reg[0]) : '0;
        result.error       = err;
        result.count_after = COUNT_OUT_BITS'(count_next);
        result.is_empty    = (count_next == '0);
    end

endmodule
`default_nettype wire

### rtl/lru_order_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// A command waits in the input register until the result register is free,
// and the order update lands in the result register when it fires.
// Throughput: one command per cycle while the result channel does not
// stall, set by the parallel key match and slot shift in the order stack.
// Reset clears the entry count and both valid flags; the key slots are
// left as they are and are never read before they are written.
// ----------------------------------------------------------------------------
// LRU order tracker
// Ordered set of distinct nonzero keys with add, remove, touch and pop of
// the least recently used key; one result per command with an error code.
// ----------------------------------------------------------------------------
module lru_order_tracker
    import lot_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int KEY_BITS = DEFAULT_KEY_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [1:0]                cmd,
    input  wire logic [KEY_PORT_BITS-1:0]  key,

    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output logic [POPPED_BITS-1:0]         popped_key,
    output logic [2:0]                     error_code,
    output logic [COUNT_OUT_BITS-1:0]      count_after,
    output logic                           is_empty
);

    lot_cmd_t            req_cmd_reg;
    logic [KEY_BITS-1:0] req_key_reg;
    logic                stage_valid_reg;
    logic                stage_valid_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    lot_result_t         rsp_reg;
    lot_result_t         result;

    logic advance;
    logic fire;
    logic accept;

    // The staged command moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = stage_valid_reg && advance;
    assign req_stall = stage_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        priority if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    assign rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_cmd_reg <= lot_cmd_t'(cmd);
            req_key_reg <= KEY_BITS'(key);
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    lot_stack #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (req_cmd_reg),
        .key    (req_key_reg),
        .result (result)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign popped_key  = rsp_reg.popped_key;
    assign error_code  = rsp_reg.error;
    assign count_after = rsp_reg.count_after;
    assign is_empty    = rsp_reg.is_empty;

endmodule
`default_nettype wire

### rtl/lot_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU order tracker checker
// Watches the result channel of the top level for consistency between the
// reported fields and for a stable payload while stalled.
// ----------------------------------------------------------------------------
module lot_checker
    import lot_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rsp_valid,
    input  wire logic                      rsp_stall,
    input  wire logic [POPPED_BITS-1:0]    popped_key,
    input  wire logic [2:0]                error_code,
    input  wire logic [COUNT_OUT_BITS-1:0] count_after,
    input  wire logic                      is_empty
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(popped_key)
            && $stable(error_code) && $stable(count_after) && $stable(is_empty))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count_after == '0)))
        else $error("empty flag disagrees with count");

    a_err_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (error_code != ERR_OK) |-> (popped_key == '0))
        else $error("failed command returned a key");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (error_code == ERR_EMPTY) |-> is_empty)
        else $error("empty error reported with keys held");

endmodule

bind lru_order_tracker lot_checker u_lot_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .popped_key  (popped_key),
    .error_code  (error_code),
    .count_after (count_after),
    .is_empty    (is_empty)
);
`default_nettype wire
